@@ rtl/smoothstep_lattice_interpolator_core_assert.svh @@
// Assertion macros shared by the interpolator RTL.
// Every macro expects i_clk and i_rst_n in scope of the including module.
`ifndef SMOOTHSTEP_LATTICE_INTERPOLATOR_CORE_ASSERT_SVH
`define SMOOTHSTEP_LATTICE_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sli assertion failed");

// Next-cycle implication, checked out of reset.
`define SLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sli assertion failed");

`endif

@@ rtl/sli_pkg.sv @@
// Shared types, widths and helpers for the smoothstep lattice interpolator.
// No dependencies.
package sli_pkg;

    localparam int SHIFT_W        = 3;
    localparam int SHIFT_MAX      = (1 << SHIFT_W) - 1;
    localparam int CORNER_W       = 8;
    localparam int OFFSET_W       = 7;
    localparam int PIXEL_W        = 8;
    localparam int MAX_OCTAVE_DEF = 7;
    localparam int LATENCY        = 7;
    localparam int TRI_W          = 5;   // holds 3*shift
    localparam int HEX_W          = 6;   // holds 6*shift

    // Per-cycle control seen by every stage.
    typedef struct packed {
        logic               adv;
        logic [SHIFT_W-1:0] shift;
    } t_pipe_ctl;

    // 3*k, the log2 of the cubed cell size.
    function automatic logic [TRI_W-1:0] tri_shift(input logic [SHIFT_W-1:0] k);
        logic [TRI_W-1:0] kx;
        kx = TRI_W'(k);
        return (kx << 1) + kx;
    endfunction

endpackage

@@ rtl/sli_ease.sv @@
// Two-stage smoothstep weight W(j) = j*j*(3s-2j) for one axis.
// Depends on sli_pkg.
module sli_ease #(
    parameter int KMAX = sli_pkg::MAX_OCTAVE_DEF
) (
    input  logic                         i_clk,
    input  sli_pkg::t_pipe_ctl           i_ctl,
    input  logic [sli_pkg::OFFSET_W-1:0] i_offset,
    output logic [3*KMAX-1:0]            o_weight
);

    localparam int JW = KMAX;
    localparam int TW = KMAX + 2;

    logic [KMAX:0]     s_size;
    logic [JW-1:0]     s_mask;
    logic [JW-1:0]     s_j;
    logic [TW-1:0]     s_tail;
    logic [2*JW-1:0]   n_jsq;
    logic [2*JW-1:0]   r_jsq;
    logic [TW-1:0]     r_tail;
    logic [3*JW+1:0]   s_prod;
    logic [3*KMAX-1:0] r_weight;

    always_comb begin
        s_size = (KMAX+1)'(1) << i_ctl.shift;
        s_mask = JW'(s_size - (KMAX+1)'(1));
        s_j    = i_offset[JW-1:0] & s_mask;
        // 3s - 2j, always positive since j < s
        s_tail = (TW'(s_size) << 1) + TW'(s_size) - (TW'(s_j) << 1);
        n_jsq  = (2*JW)'(s_j) * (2*JW)'(s_j);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_jsq  <= n_jsq;
            r_tail <= s_tail;
        end
    end

    assign s_prod = (3*JW+2)'(r_jsq) * (3*JW+2)'(r_tail);

    // W < s^3 <= 2^(3*KMAX)
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_weight <= s_prod[3*KMAX-1:0];
        end
    end

    assign o_weight = r_weight;

endmodule

@@ rtl/sli_lerp.sv @@
// Two-stage scaled lerp: lo*2^(3k) + (hi-lo)*w, exact integer.
// Depends on sli_pkg.
module sli_lerp #(
    parameter int VW = sli_pkg::CORNER_W,
    parameter int WW = 3 * sli_pkg::MAX_OCTAVE_DEF
) (
    input  logic               i_clk,
    input  sli_pkg::t_pipe_ctl i_ctl,
    input  logic [VW-1:0]      i_lo,
    input  logic [VW-1:0]      i_hi,
    input  logic [WW-1:0]      i_weight,
    output logic [VW+WW-1:0]   o_blend
);

    localparam int OW = VW + WW;
    localparam int PW = VW + WW + 2;

    logic signed [VW:0]   s_diff;
    logic signed [WW:0]   s_wt;
    logic signed [PW-1:0] r_prod;
    logic [VW-1:0]        r_lo;
    logic [OW-1:0]        s_base;
    logic signed [PW-1:0] s_sum;
    logic [OW-1:0]        r_blend;

    assign s_diff = $signed({1'b0, i_hi}) - $signed({1'b0, i_lo});
    assign s_wt   = $signed({1'b0, i_weight});

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= PW'(s_diff) * PW'(s_wt);
            r_lo   <= i_lo;
        end
    end

    always_comb begin
        s_base = OW'(r_lo) << sli_pkg::tri_shift(i_ctl.shift);
        // sum is a convex blend scaled by 2^(3k), never negative
        s_sum  = $signed({2'b00, s_base}) + r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_blend <= s_sum[OW-1:0];
        end
    end

    assign o_blend = r_blend;

endmodule

@@ rtl/smoothstep_lattice_interpolator_core.sv @@
// Smoothstep lattice interpolator top: ease, row lerps, column lerp, output.
// Depends on sli_pkg, sli_ease, sli_lerp and the assertion macro header.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | four corners, offset_x, offset_y
//  out     | source    | o_out_valid / i_out_stall  | pixel_value
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | octave_shift
//
// One beat per cycle sustained unless the output stalls; stages: 2 ease, 2 row lerp,
// 2 column lerp, 1 output shift register.
// All stages advance together; a stalled output beat freezes the whole pipe.
// Synchronous active-low reset clears valid bits and octave_shift to 0.
// Stages read the octave register directly; user must change it only idle (unenforced).
`include "smoothstep_lattice_interpolator_core_assert.svh"

module smoothstep_lattice_interpolator_core #(
    parameter int MAX_OCTAVE = sli_pkg::MAX_OCTAVE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sli_pkg::CORNER_W-1:0] i_corner_top_left,
    input  logic [sli_pkg::CORNER_W-1:0] i_corner_top_right,
    input  logic [sli_pkg::CORNER_W-1:0] i_corner_bottom_left,
    input  logic [sli_pkg::CORNER_W-1:0] i_corner_bottom_right,
    input  logic [sli_pkg::OFFSET_W-1:0] i_offset_x,
    input  logic [sli_pkg::OFFSET_W-1:0] i_offset_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sli_pkg::PIXEL_W-1:0]  o_pixel_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sli_pkg::SHIFT_W-1:0]  i_cfg_data
);

    localparam int KMAX = (MAX_OCTAVE < sli_pkg::SHIFT_MAX) ? MAX_OCTAVE : sli_pkg::SHIFT_MAX;
    localparam int CW   = sli_pkg::CORNER_W;
    localparam int WW   = 3 * KMAX;
    localparam int RW   = CW + WW;
    localparam int NW   = RW + WW;
    localparam int LAT  = sli_pkg::LATENCY;

    logic [sli_pkg::SHIFT_W-1:0] r_shift;
    logic [sli_pkg::SHIFT_W-1:0] s_k;
    sli_pkg::t_pipe_ctl          s_ctl;
    logic [LAT-1:0]              r_vld;

    logic [CW-1:0] r_tl_d1, r_tr_d1, r_bl_d1, r_br_d1;
    logic [CW-1:0] r_tl_d2, r_tr_d2, r_bl_d2, r_br_d2;
    logic [WW-1:0] s_wx, s_wy;
    logic [WW-1:0] r_wy_d1, r_wy_d2;
    logic [RW-1:0] s_top, s_bot;
    logic [NW-1:0] s_num;
    logic [sli_pkg::HEX_W-1:0]   s_hex;
    logic [sli_pkg::PIXEL_W-1:0] r_pixel;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (i_cfg_valid) begin
            r_shift <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // octave saturates at the build limit
    assign s_k = (r_shift > sli_pkg::SHIFT_W'(KMAX)) ? sli_pkg::SHIFT_W'(KMAX) : r_shift;

    assign o_in_stall = r_vld[LAT-1] & i_out_stall;
    assign s_ctl.adv   = ~o_in_stall;
    assign s_ctl.shift = s_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_ctl.adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // corners wait out the two ease stages
    always_ff @(posedge i_clk) begin
        if (s_ctl.adv) begin
            r_tl_d1 <= i_corner_top_left;
            r_tr_d1 <= i_corner_top_right;
            r_bl_d1 <= i_corner_bottom_left;
            r_br_d1 <= i_corner_bottom_right;
            r_tl_d2 <= r_tl_d1;
            r_tr_d2 <= r_tr_d1;
            r_bl_d2 <= r_bl_d1;
            r_br_d2 <= r_br_d1;
            r_wy_d1 <= s_wy;
            r_wy_d2 <= r_wy_d1;
        end
    end

    sli_ease #(.KMAX(KMAX)) u_ease_x (
        .i_clk    (i_clk),
        .i_ctl    (s_ctl),
        .i_offset (i_offset_x),
        .o_weight (s_wx)
    );

    sli_ease #(.KMAX(KMAX)) u_ease_y (
        .i_clk    (i_clk),
        .i_ctl    (s_ctl),
        .i_offset (i_offset_y),
        .o_weight (s_wy)
    );

    sli_lerp #(.VW(CW), .WW(WW)) u_lerp_top (
        .i_clk    (i_clk),
        .i_ctl    (s_ctl),
        .i_lo     (r_tl_d2),
        .i_hi     (r_tr_d2),
        .i_weight (s_wx),
        .o_blend  (s_top)
    );

    sli_lerp #(.VW(CW), .WW(WW)) u_lerp_bot (
        .i_clk    (i_clk),
        .i_ctl    (s_ctl),
        .i_lo     (r_bl_d2),
        .i_hi     (r_br_d2),
        .i_weight (s_wx),
        .o_blend  (s_bot)
    );

    sli_lerp #(.VW(RW), .WW(WW)) u_lerp_col (
        .i_clk    (i_clk),
        .i_ctl    (s_ctl),
        .i_lo     (s_top),
        .i_hi     (s_bot),
        .i_weight (r_wy_d2),
        .o_blend  (s_num)
    );

    // divide by D^2 = 2^(6k); the quotient never exceeds one byte
    assign s_hex = {sli_pkg::tri_shift(s_k), 1'b0};

    always_ff @(posedge i_clk) begin
        if (s_ctl.adv) begin
            r_pixel <= sli_pkg::PIXEL_W'(s_num >> s_hex);
        end
    end

    assign o_out_valid   = r_vld[LAT-1];
    assign o_pixel_value = r_pixel;

    `SLI_ASSERT_IMPL(a_stall_only_when_full, o_in_stall, r_vld[LAT-1] && i_out_stall)
    `SLI_ASSERT_NEXT(a_accept_enters_pipe, i_in_valid && !o_in_stall, r_vld[0])
    `SLI_ASSERT_NEXT(a_stall_freezes_pipe, o_in_stall, $stable(r_vld) && $stable(r_pixel))
    `SLI_ASSERT_NEXT(a_idle_drains, !i_in_valid && !o_in_stall, !r_vld[0])

endmodule

@@ test/tb_smoothstep_lattice_interpolator_core.sv @@
// Self-checking testbench for smoothstep_lattice_interpolator_core: a directed table,
// then random pixels over several octave settings; beats checked to table or local blend.
// Depends on sli_pkg and the RTL of the interpolator.
module tb_smoothstep_lattice_interpolator_core;

    localparam int PERIOD_HALF = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_PIXELS = 195;
    localparam int IDLE_PCT = 13;
    localparam int LONG_HOLD = 80;

    typedef struct packed {
        logic [sli_pkg::CORNER_W-1:0] tl;
        logic [sli_pkg::CORNER_W-1:0] tr;
        logic [sli_pkg::CORNER_W-1:0] bl;
        logic [sli_pkg::CORNER_W-1:0] br;
        logic [sli_pkg::OFFSET_W-1:0] ox;
        logic [sli_pkg::OFFSET_W-1:0] oy;
    } t_pix_in;

    typedef struct packed {
        logic [sli_pkg::SHIFT_W-1:0] octave;
        t_pix_in                     pix;
        logic                        known;
        logic [sli_pkg::PIXEL_W-1:0] pixel;
    } t_plan_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [sli_pkg::CORNER_W-1:0] i_corner_top_left;
    logic [sli_pkg::CORNER_W-1:0] i_corner_top_right;
    logic [sli_pkg::CORNER_W-1:0] i_corner_bottom_left;
    logic [sli_pkg::CORNER_W-1:0] i_corner_bottom_right;
    logic [sli_pkg::OFFSET_W-1:0] i_offset_x;
    logic [sli_pkg::OFFSET_W-1:0] i_offset_y;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [sli_pkg::PIXEL_W-1:0]  o_pixel_value;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [sli_pkg::SHIFT_W-1:0]  i_cfg_data;

    logic [sli_pkg::PIXEL_W-1:0]  pending_pixels[$];
    logic [sli_pkg::SHIFT_W-1:0]  octave_now;
    int                           mismatches;
    int                           cycle_count;
    int                           hold_left;
    bit                           quiet;
    bit                           hold_request;

    smoothstep_lattice_interpolator_core u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_corner_top_left     (i_corner_top_left),
        .i_corner_top_right    (i_corner_top_right),
        .i_corner_bottom_left  (i_corner_bottom_left),
        .i_corner_bottom_right (i_corner_bottom_right),
        .i_offset_x            (i_offset_x),
        .i_offset_y            (i_offset_y),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_pixel_value         (o_pixel_value),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #PERIOD_HALF i_clk = 1'b1;
        #PERIOD_HALF i_clk = 1'b0;
    end

    // Exact rational blend: weights scaled by s^3, floor is a shift by 6*k.
    function automatic logic [sli_pkg::PIXEL_W-1:0] smooth_blend(
        t_pix_in c, logic [sli_pkg::SHIFT_W-1:0] octave);
        int unsigned k;
        logic [63:0] s, mask, d3, jx, jy, wx, wy, top, bot, num;
        k = octave;
        if (k > sli_pkg::MAX_OCTAVE_DEF)
            k = sli_pkg::MAX_OCTAVE_DEF;
        s    = 64'd1 << k;
        mask = s - 64'd1;
        d3   = s * s * s;
        jx   = 64'(c.ox) & mask;
        jy   = 64'(c.oy) & mask;
        wx   = jx * jx * (64'd3 * s - 64'd2 * jx);
        wy   = jy * jy * (64'd3 * s - 64'd2 * jy);
        top  = 64'(c.tl) * (d3 - wx) + 64'(c.tr) * wx;
        bot  = 64'(c.bl) * (d3 - wx) + 64'(c.br) * wx;
        num  = top * (d3 - wy) + bot * wy;
        return sli_pkg::PIXEL_W'(num >> (6 * k));
    endfunction

    // Corners lean toward the rails now and then.
    function automatic logic [sli_pkg::CORNER_W-1:0] pick_corner();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return sli_pkg::CORNER_W'($urandom);
    endfunction

    function automatic logic [sli_pkg::OFFSET_W-1:0] pick_offset(
        logic [sli_pkg::SHIFT_W-1:0] octave);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return sli_pkg::OFFSET_W'((1 << octave) - 1);
        if (r == 2)
            return '1;
        return sli_pkg::OFFSET_W'($urandom_range(0, (1 << sli_pkg::OFFSET_W) - 1));
    endfunction

    // Called right after a rising edge; leaves time at the edge that took the beat.
    task automatic send_pixel(input t_pix_in c, input logic [sli_pkg::PIXEL_W-1:0] want);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_corner_top_left     <= c.tl;
        i_corner_top_right    <= c.tr;
        i_corner_bottom_left  <= c.bl;
        i_corner_bottom_right <= c.br;
        i_offset_x            <= c.ox;
        i_offset_y            <= c.oy;
        i_in_valid            <= 1'b1;
        pending_pixels.push_back(want);
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Octave changes only with the pipe empty.
    task automatic set_octave(input logic [sli_pkg::SHIFT_W-1:0] octave);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= octave;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        octave_now = octave;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: pixel_value expected none, actual %0d", $time, o_pixel_value);
            end else begin
                if (o_pixel_value !== pending_pixels[0]) begin
                    mismatches++;
                    $display("%0t: pixel_value expected %0d, actual %0d",
                             $time, pending_pixels[0], o_pixel_value);
                end
                void'(pending_pixels.pop_front());
            end
        end
    end

    // Output side back-pressure, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_plan_row                   plan [19];
        logic [sli_pkg::SHIFT_W-1:0] phase_octave [10];
        logic [sli_pkg::PIXEL_W-1:0] want;
        t_pix_in                     c;

        plan = '{
            // zero octave straight out of reset: top-left passes through
            '{3'd0, '{8'h5A, 8'hA5, 8'h3C, 8'hC3, 7'h7F, 7'h7F}, 1'b1, 8'h5A},
            '{3'd0, '{8'hFF, 8'h00, 8'h00, 8'h00, 7'h55, 7'h2A}, 1'b1, 8'hFF},
            '{3'd0, '{8'h00, 8'hFF, 8'hFF, 8'hFF, 7'h7F, 7'h7F}, 1'b1, 8'h00},
            // widest cell
            '{3'd7, '{8'h80, 8'hFF, 8'h00, 8'h7F, 7'h00, 7'h00}, 1'b1, 8'h80},
            '{3'd7, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F, 7'h7F}, 1'b1, 8'hFF},
            '{3'd7, '{8'h00, 8'h00, 8'h00, 8'h00, 7'h7F, 7'h7F}, 1'b1, 8'h00},
            '{3'd7, '{8'h00, 8'hFF, 8'h00, 8'hFF, 7'h7F, 7'h00}, 1'b0, 8'h00},
            '{3'd7, '{8'h00, 8'h00, 8'hFF, 8'hFF, 7'h00, 7'h7F}, 1'b0, 8'h00},
            '{3'd7, '{8'hFF, 8'h00, 8'h00, 8'hFF, 7'h40, 7'h40}, 1'b0, 8'h00},
            '{3'd7, '{8'h12, 8'h34, 8'h56, 8'h78, 7'h7F, 7'h7F}, 1'b0, 8'h00},
            '{3'd7, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 7'h7F, 7'h7F}, 1'b0, 8'h00},
            // offset bits above the octave are dropped
            '{3'd3, '{8'hAB, 8'hCD, 8'hEF, 8'h01, 7'h78, 7'h70}, 1'b1, 8'hAB},
            '{3'd3, '{8'h00, 8'hFF, 8'h00, 8'hFF, 7'h7F, 7'h0F}, 1'b0, 8'h00},
            '{3'd3, '{8'h10, 8'h20, 8'h30, 8'h40, 7'h2A, 7'h55}, 1'b0, 8'h00},
            '{3'd1, '{8'h00, 8'hFF, 8'h00, 8'hFF, 7'h7E, 7'h01}, 1'b0, 8'h00},
            '{3'd1, '{8'h00, 8'hFF, 8'hFF, 8'h00, 7'h01, 7'h01}, 1'b0, 8'h00},
            '{3'd6, '{8'hC8, 8'h00, 8'hFF, 8'h37, 7'h3F, 7'h40}, 1'b0, 8'h00},
            '{3'd6, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h3F, 7'h3F}, 1'b1, 8'hFF},
            '{3'd0, '{8'h33, 8'hFF, 8'hFF, 8'hFF, 7'h7F, 7'h7F}, 1'b1, 8'h33}
        };
        phase_octave = '{3'd5, 3'd2, 3'd4, 3'd7, 3'd0, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0};
        phase_octave[9] = sli_pkg::SHIFT_W'($urandom_range(0, sli_pkg::SHIFT_MAX));

        mismatches   = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        cycle_count  = 0;
        octave_now   = '0;

        i_rst_n               <= 1'b0;
        i_in_valid            <= 1'b0;
        i_corner_top_left     <= '0;
        i_corner_top_right    <= '0;
        i_corner_bottom_left  <= '0;
        i_corner_bottom_right <= '0;
        i_offset_x            <= '0;
        i_offset_y            <= '0;
        i_cfg_valid           <= 1'b0;
        i_cfg_data            <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].octave != octave_now)
                set_octave(plan[r].octave);
            want = plan[r].known ? plan[r].pixel : smooth_blend(plan[r].pix, octave_now);
            send_pixel(plan[r].pix, want);
        end

        foreach (phase_octave[p]) begin
            set_octave(phase_octave[p]);
            quiet = (p == 3);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                if (p == 1 && n == 20)
                    hold_request = 1'b1;
                c.tl = pick_corner();
                c.tr = pick_corner();
                c.bl = pick_corner();
                c.br = pick_corner();
                c.ox = pick_offset(octave_now);
                c.oy = pick_offset(octave_now);
                send_pixel(c, smooth_blend(c, octave_now));
            end
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (sli_pkg::LATENCY + 4) @(posedge i_clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
